### rtl/core/snorm_pkg.sv
// Package for the stick axis normalizer: default widths and the
// configuration register map. No dependencies.
`default_nettype none

package snorm_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 14;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_BOUND  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_BOUND = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THROTTLE   = 3'd5;

endpackage

`default_nettype wire

### rtl/core/snorm_sample_if.sv
// Input stream interface: one raw stick sample per word.
// Depends on snorm_pkg for the default width.
`default_nettype none

interface snorm_sample_if #(
    parameter int SAMPLE_BITS = snorm_pkg::SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

### rtl/core/snorm_result_if.sv
// Output stream interface: one normalized Q value per word.
// Depends on snorm_pkg for the default width.
`default_nettype none

interface snorm_result_if #(
    parameter int FRACTION_BITS = snorm_pkg::FRACTION_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic signed [FRACTION_BITS+1:0] normalized_value;

    modport source (output valid, output normalized_value, input ready);
    modport sink   (input valid, input normalized_value, output ready);
endinterface

`default_nettype wire

### rtl/core/snorm_div.sv
// Pipelined restoring fractional divider, one quotient bit per stage.
// Computes (num << FRACTION_BITS) / den for num <= den. Depends on snorm_pkg for the default widths.
`default_nettype none

module snorm_div #(
    parameter int SAMPLE_BITS   = snorm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = snorm_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [SAMPLE_BITS-1:0]   in_num,
    input  wire logic [SAMPLE_BITS-1:0]   in_den,
    input  wire logic                     in_neg,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [FRACTION_BITS:0]        out_quot,
    output logic                          out_neg
);

    localparam int S      = SAMPLE_BITS;
    localparam int F      = FRACTION_BITS;
    localparam int STAGES = F + 1;
    localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] neg_reg;
    logic [S-1:0]      r_reg   [STAGES];
    logic [S-1:0]      den_reg [STAGES];
    logic [F:0]        q_reg   [STAGES];
    logic [STAGES:0]   adv;

    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic         src_valid;
            logic         src_neg;
            logic [S-1:0] src_den;
            logic [S:0]   trial;
            logic [S+1:0] diff;
            logic         ge;
            logic [S-1:0] r_next;
            logic [F:0]   q_next;

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_neg   = in_neg;
                assign src_den   = in_den;
                assign trial     = {1'b0, in_num};
                assign q_next    = {{F{1'b0}}, ge};
            end
            else
            begin : g_rest
                assign src_valid = v_reg[k-1];
                assign src_neg   = neg_reg[k-1];
                assign src_den   = den_reg[k-1];
                assign trial     = {r_reg[k-1], 1'b0};
                assign q_next    = {q_reg[k-1][F-1:0], ge};
            end

            assign diff   = {1'b0, trial} - {2'b00, src_den};
            assign ge     = !diff[S+1];
            assign r_next = ge ? diff[S-1:0] : trial[S-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (adv[k])
                begin
                    v_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[k] && src_valid)
                begin
                    r_reg[k]   <= r_next;
                    den_reg[k] <= src_den;
                    q_reg[k]   <= q_next;
                    neg_reg[k] <= src_neg;
                end
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = v_reg[STAGES-1];
    assign out_quot  = q_reg[STAGES-1];
    assign out_neg   = neg_reg[STAGES-1];

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_quot <= ONE_Q)
        else $error("quotient above one");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] |-> r_reg[0] < den_reg[0])
        else $error("first stage remainder not below divisor");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            out_valid && $stable(out_quot) && $stable(out_neg))
        else $error("output word changed while stalled");

endmodule

`default_nettype wire

### rtl/core/stick_axis_normalizer.sv
// Pipeline from accepted sample to result word: clamp, offset/span select,
// one divider stage per quotient bit, then deadband/invert/clamp into the
// output register.
// Throughput: one word per cycle unless the result stream stalls; every stage advances on its own ready.
// Reset clears all valid bits and loads the register reset values.
`default_nettype none

module stick_axis_normalizer #(
    parameter int SAMPLE_BITS   = snorm_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = snorm_pkg::FRACTION_BITS_DEF,
    parameter int CFG_W = (SAMPLE_BITS > FRACTION_BITS + 1) ? SAMPLE_BITS : FRACTION_BITS + 1
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    snorm_sample_if.sink                                 sample,
    snorm_result_if.source                               result,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [snorm_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]                        cfg_wr_data
);

    localparam int S = SAMPLE_BITS;
    localparam int F = FRACTION_BITS;
    localparam logic [F:0]   ONE_Q   = {1'b1, {F{1'b0}}};
    localparam logic [S-1:0] DEN_ONE = {{(S-1){1'b0}}, 1'b1};

    // configuration registers
    logic signed [S-1:0] low_reg;
    logic signed [S-1:0] high_reg;
    logic signed [S-1:0] center_reg;
    logic                invert_reg;
    logic [F:0]          deadband_reg;
    logic                throttle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg      <= {1'b1, {(S-1){1'b0}}};
            high_reg     <= {1'b0, {(S-1){1'b1}}};
            center_reg   <= '0;
            invert_reg   <= 1'b0;
            deadband_reg <= '0;
            throttle_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                snorm_pkg::REG_LOW_BOUND:  low_reg      <= cfg_wr_data[S-1:0];
                snorm_pkg::REG_HIGH_BOUND: high_reg     <= cfg_wr_data[S-1:0];
                snorm_pkg::REG_CENTER:     center_reg   <= cfg_wr_data[S-1:0];
                snorm_pkg::REG_INVERT:     invert_reg   <= cfg_wr_data[0];
                snorm_pkg::REG_DEADBAND:   deadband_reg <= cfg_wr_data[F:0];
                snorm_pkg::REG_THROTTLE:   throttle_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ordered bounds, clamped center; user keeps them static while words are in flight (not enforced)
    logic signed [S-1:0] lo;
    logic signed [S-1:0] hi;
    logic signed [S-1:0] ctr;

    always_comb
    begin
        lo  = (low_reg < high_reg) ? low_reg : high_reg;
        hi  = (low_reg < high_reg) ? high_reg : low_reg;
        ctr = (center_reg < lo) ? lo : ((center_reg > hi) ? hi : center_reg);
    end

    // handshake chain
    logic div_in_ready;
    logic div_out_valid;
    logic v1_reg;
    logic v2_reg;
    logic vf_reg;
    logic rdy1;
    logic rdy2;
    logic rdyf;

    assign rdyf         = !vf_reg || result.ready;
    assign rdy2         = !v2_reg || div_in_ready;
    assign rdy1         = !v1_reg || rdy2;
    assign sample.ready = rdy1;

    // stage 1: clamp sample
    logic signed [S-1:0] x1_reg;
    logic signed [S-1:0] x1_next;

    always_comb
    begin
        if (sample.raw_sample < lo)
            x1_next = lo;
        else if (sample.raw_sample > hi)
            x1_next = hi;
        else
            x1_next = sample.raw_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (rdy1)
        begin
            v1_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            x1_reg <= x1_next;
        end
    end

    // stage 2: pick numerator, span and side
    logic [S-1:0] num2_reg;
    logic [S-1:0] den2_reg;
    logic         neg2_reg;
    logic [S-1:0] num2_next;
    logic [S-1:0] den2_next;
    logic         neg2_next;
    logic [S:0]   num_full;
    logic [S:0]   den_full;

    always_comb
    begin
        if (throttle_reg)
        begin
            num_full  = {x1_reg[S-1], x1_reg} - {lo[S-1], lo};
            den_full  = {hi[S-1], hi} - {lo[S-1], lo};
            neg2_next = 1'b0;
        end
        else if (x1_reg >= ctr)
        begin
            num_full  = {x1_reg[S-1], x1_reg} - {ctr[S-1], ctr};
            den_full  = {hi[S-1], hi} - {ctr[S-1], ctr};
            neg2_next = 1'b0;
        end
        else
        begin
            num_full  = {ctr[S-1], ctr} - {x1_reg[S-1], x1_reg};
            den_full  = {ctr[S-1], ctr} - {lo[S-1], lo};
            neg2_next = 1'b1;
        end
        num2_next = num_full[S-1:0];
        den2_next = (den_full[S-1:0] == '0) ? DEN_ONE : den_full[S-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            num2_reg <= num2_next;
            den2_reg <= den2_next;
            neg2_reg <= neg2_next;
        end
    end

    // divider
    logic [F:0] div_quot;
    logic       div_neg;

    snorm_div #(
        .SAMPLE_BITS   (S),
        .FRACTION_BITS (F)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (div_in_ready),
        .in_num    (num2_reg),
        .in_den    (den2_reg),
        .in_neg    (neg2_reg),
        .out_valid (div_out_valid),
        .out_ready (rdyf),
        .out_quot  (div_quot),
        .out_neg   (div_neg)
    );

    // final stage: deadband, invert, clamp; throttle mode only inverts
    logic signed [F+1:0] value_reg;
    logic signed [F+1:0] value_next;
    logic [F:0]          mag;
    logic                neg;

    always_comb
    begin
        mag = div_quot;
        neg = div_neg ^ invert_reg;
        if (mag < deadband_reg)
            mag = '0;
        if (mag > ONE_Q)
            mag = ONE_Q;
        if (throttle_reg)
        begin
            if (invert_reg)
                value_next = {1'b0, ONE_Q} - {1'b0, div_quot};
            else
                value_next = {1'b0, div_quot};
        end
        else if (neg)
        begin
            value_next = -{1'b0, mag};
        end
        else
        begin
            value_next = {1'b0, mag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
        end
        else if (rdyf)
        begin
            vf_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdyf && div_out_valid)
        begin
            value_reg <= value_next;
        end
    end

    assign result.valid            = vf_reg;
    assign result.normalized_value = value_reg;

    a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (num2_reg <= den2_reg) && (den2_reg != '0))
        else $error("offset exceeds span or span is zero");

    a_centered_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vf_reg && !throttle_reg) |->
            (value_reg <= $signed({1'b0, ONE_Q})) && (value_reg >= -$signed({1'b0, ONE_Q})))
        else $error("centered result out of range");

    a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vf_reg && throttle_reg) |->
            !value_reg[F+1] && (value_reg <= $signed({1'b0, ONE_Q})))
        else $error("throttle result out of range");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for stick_axis_normalizer: directed and random raw samples
// against a built-in Q1.14 predictor, with random idling on both streams.
// Depends on snorm_pkg, snorm_sample_if, snorm_result_if and the normalizer RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int SAMPLE_BITS    = snorm_pkg::SAMPLE_BITS_DEF;
    localparam int FRACTION_BITS  = snorm_pkg::FRACTION_BITS_DEF;
    localparam int CFG_W          = (SAMPLE_BITS > FRACTION_BITS + 1) ?
                                    SAMPLE_BITS : FRACTION_BITS + 1;
    localparam int LATENCY        = FRACTION_BITS + 4;
    localparam longint ONE_Q      = longint'(1) << FRACTION_BITS;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [snorm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [snorm_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [snorm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wr_data;

    snorm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
    snorm_result_if #(.FRACTION_BITS(FRACTION_BITS)) res ();

    stick_axis_normalizer #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .sample(smp),
        .result(res),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the axis calibration
    logic signed [SAMPLE_BITS-1:0] cfg_low;
    logic signed [SAMPLE_BITS-1:0] cfg_high;
    logic signed [SAMPLE_BITS-1:0] cfg_center;
    logic                          cfg_invert;
    logic [FRACTION_BITS:0]        cfg_deadband;
    logic                          cfg_throttle;

    logic signed [SAMPLE_BITS-1:0]     raw_pending_q[$];
    logic signed [FRACTION_BITS+1:0]   norm_expected_q[$];
    logic signed [FRACTION_BITS+1:0]   norm_want;

    int  err_cnt = 0;
    int  send_gap;
    int  recv_gap;
    int  quiet_cycles = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    bit  hold_off = 1'b0;

    function automatic longint scaled_ratio(input longint num, input longint den);
        return (num << FRACTION_BITS) / ((den < 1) ? 1 : den);
    endfunction

    function automatic logic signed [FRACTION_BITS+1:0] normalize_sample(
        input logic signed [SAMPLE_BITS-1:0] raw
    );
        longint lo, hi, x, c, mag, v;
        bit     neg;
        lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
        hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
        x = raw;
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        if (cfg_throttle)
        begin
            v = scaled_ratio(x - lo, hi - lo);
            if (cfg_invert) v = ONE_Q - v;
            if (v < 0) v = 0;
            if (v > ONE_Q) v = ONE_Q;
        end
        else
        begin
            c = cfg_center;
            if (c < lo) c = lo;
            if (c > hi) c = hi;
            if (x >= c)
            begin
                mag = scaled_ratio(x - c, hi - c);
                neg = 1'b0;
            end
            else
            begin
                mag = scaled_ratio(c - x, c - lo);
                neg = 1'b1;
            end
            if (mag < longint'(cfg_deadband)) mag = 0;
            if (cfg_invert) neg = !neg;
            if (mag > ONE_Q) mag = ONE_Q;
            v = neg ? -mag : mag;
        end
        return v[FRACTION_BITS+1:0];
    endfunction

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 6)) : 0;
    endfunction

    function automatic int rand_raw();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int pick_sample();
        int lo, hi, c, r;
        lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
        hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
        r = $urandom_range(0, 19);
        if (r < 14)
            return lo + int'($urandom_range(0, hi - lo));
        else if (r < 17)
            return rand_raw();
        else if (r == 17)
            return $urandom_range(0, 1) ? 32767 : -32768;
        else if (r == 18)
            return $urandom_range(0, 1) ? hi : lo;
        c = cfg_center;
        c = c + int'($urandom_range(0, 4)) - 2;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c;
    endfunction

    task automatic queue_sample(input int v);
        raw_pending_q.push_back(v[SAMPLE_BITS-1:0]);
    endtask

    task automatic write_reg(input logic [snorm_pkg::CFG_INDEX_BITS-1:0] idx,
                             input int data);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data[CFG_W-1:0];
        case (idx)
            snorm_pkg::REG_LOW_BOUND:  cfg_low      = data[SAMPLE_BITS-1:0];
            snorm_pkg::REG_HIGH_BOUND: cfg_high     = data[SAMPLE_BITS-1:0];
            snorm_pkg::REG_CENTER:     cfg_center   = data[SAMPLE_BITS-1:0];
            snorm_pkg::REG_INVERT:     cfg_invert   = data[0];
            snorm_pkg::REG_DEADBAND:   cfg_deadband = data[FRACTION_BITS:0];
            snorm_pkg::REG_THROTTLE:   cfg_throttle = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_axis(input int lo, input int hi, input int c,
                                input int inv, input int db, input int thr);
        write_reg(snorm_pkg::REG_LOW_BOUND, lo);
        write_reg(snorm_pkg::REG_HIGH_BOUND, hi);
        write_reg(snorm_pkg::REG_CENTER, c);
        write_reg(snorm_pkg::REG_INVERT, inv);
        write_reg(snorm_pkg::REG_DEADBAND, db);
        write_reg(snorm_pkg::REG_THROTTLE, thr);
    endtask

    task automatic wait_idle();
        while (raw_pending_q.size() != 0 || smp.valid || norm_expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_axis();
        int a, b, c, lo, hi, db, r;
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            a = -32768;
            b = 32767;
        end
        else if (r == 1)
        begin
            a = rand_raw();
            b = a;
        end
        else if (r == 2)
        begin
            a = rand_raw();
            b = a + int'($urandom_range(0, 16)) - 8;
            if (b > 32767) b = 32767;
            if (b < -32768) b = -32768;
        end
        else
        begin
            a = rand_raw();
            b = rand_raw();
        end
        if ($urandom_range(0, 1))
        begin
            r = a;
            a = b;
            b = r;
        end
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        r = $urandom_range(0, 5);
        if (r == 0)      c = (lo + hi) / 2;
        else if (r == 1) c = lo;
        else if (r == 2) c = hi;
        else if (r == 3) c = rand_raw();
        else             c = lo + int'($urandom_range(0, hi - lo));
        r = $urandom_range(0, 9);
        if (r < 5)       db = 0;
        else if (r < 8)  db = $urandom_range(0, 2000);
        else if (r == 8) db = $urandom_range(0, 16384);
        else             db = $urandom_range(0, 65535);
        program_axis(a, b, c, $urandom_range(0, 65535), db, $urandom_range(0, 65535));
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand_raw());
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp.valid      <= 1'b0;
            smp.raw_sample <= '0;
            send_gap = 0;
        end
        else
        begin
            if (smp.valid && smp.ready)
            begin
                norm_expected_q.push_back(normalize_sample(smp.raw_sample));
                send_gap = draw_gap(send_idle_on);
            end
            else if (!smp.valid && send_gap > 0)
                send_gap--;
            if (!(smp.valid && !smp.ready))
            begin
                if (send_gap == 0 && !hold_off && raw_pending_q.size() != 0)
                begin
                    smp.valid      <= 1'b1;
                    smp.raw_sample <= raw_pending_q.pop_front();
                end
                else
                    smp.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (norm_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %0d",
                             $time, res.normalized_value);
                    err_cnt++;
                end
                else
                begin
                    norm_want = norm_expected_q.pop_front();
                    if (res.normalized_value !== norm_want)
                    begin
                        $display("%0t: normalized_value mismatch, expected %0d, got %0d",
                                 $time, norm_want, res.normalized_value);
                        err_cnt++;
                    end
                end
                recv_gap = draw_gap(recv_idle_on);
            end
            else if (recv_gap > 0)
                recv_gap--;
            res.ready <= (recv_gap == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (smp.valid && smp.ready) || (res.valid && res.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = snorm_pkg::REG_LOW_BOUND;
        cfg_wr_data    = '0;
        smp.valid      = 1'b0;
        smp.raw_sample = '0;
        res.ready      = 1'b0;
        cfg_low        = -32768;
        cfg_high       = 32767;
        cfg_center     = '0;
        cfg_invert     = 1'b0;
        cfg_deadband   = '0;
        cfg_throttle   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset calibration
        queue_sample(-32768); queue_sample(32767); queue_sample(0);
        queue_sample(1); queue_sample(-1);
        wait_idle();

        // reversed bounds
        program_axis(1000, -1000, 0, 0, 0, 0);
        queue_sample(-32768); queue_sample(32767); queue_sample(500); queue_sample(-999);
        wait_idle();

        // zero span, centered and inverted
        program_axis(500, 500, 500, 1, 0, 0);
        queue_sample(500); queue_sample(-32768);
        wait_idle();

        // zero span throttle with inversion, center outside the bounds
        program_axis(-7, -7, 30000, 1, 0, 1);
        queue_sample(-7); queue_sample(32767);
        wait_idle();

        // deadband above one
        program_axis(-32768, 32767, 100, 0, 20000, 0);
        queue_sample(32767); queue_sample(-32768); queue_sample(100);
        wait_idle();

        // full-range throttle, spare indexes must not land anywhere
        program_axis(32767, -32768, 0, 0, 16384, 1);
        write_reg(REG_SPARE_A, 16'h1234);
        write_reg(REG_SPARE_B, -1);
        queue_sample(-32768); queue_sample(32767); queue_sample(0);
        wait_idle();

        program_axis(-100, 100, 5000, 1, 0, 1);
        queue_sample(-100); queue_sample(100); queue_sample(0); queue_sample(1);
        wait_idle();

        for (int ph = 0; ph < 20; ph++)
        begin
            random_axis();
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 50; n++)
                queue_sample(pick_sample());
            if (ph % 6 == 2)
            begin
                while (raw_pending_q.size() > 25) @(posedge clk);
                hold_off = 1'b1;
                while (smp.valid || norm_expected_q.size() != 0) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        if (err_cnt == 0 && norm_expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
